@@ rtl/lgt_pkg.sv @@
// ---------------------------------------------------------------------------
// lgt_pkg: shared types and constants for the light occlusion gesture toggle
// Widths, mode codes, register indexes and the divide-by-AVG_SAMPLES
// reciprocal constants used by the calibration mean.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgt_pkg;

  localparam int AVG_SAMPLES = 20;

  localparam int SAMPLE_W   = 12;
  localparam int RATIO_W    = 16;
  localparam int COUNT_W    = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = SAMPLE_W + RATIO_W;

  // Calibration sum and sample counter
  localparam int ACC_W  = $clog2(AVG_SAMPLES * ((1 << SAMPLE_W) - 1) + 1);
  localparam int CCNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES + 1) : 1;

  // floor(n / AVG_SAMPLES) == (n * DIV_M) >> DIV_SH for every n < 2**ACC_W
  localparam int DIV_L   = $clog2(AVG_SAMPLES);
  localparam int DIV_SH  = ACC_W + DIV_L;
  localparam int DIV_M_W = ACC_W + 2;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
  localparam logic [DIV_M_W-1:0] DIV_MULT = DIV_M_W'(DIV_M);

  localparam logic [SAMPLE_W-1:0] BASELINE_RST = 12'd20;

  typedef enum logic [MODE_W-1:0] {
    MODE_CALIB = 2'd0,
    MODE_WATCH = 2'd1,
    MODE_CHECK = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_RATIO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DARK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DARK      = 2'd3;

  typedef struct packed {
    logic [RATIO_W-1:0] down_ratio;
    logic [RATIO_W-1:0] recover_ratio;
    logic [COUNT_W-1:0] min_dark_count;
    logic [COUNT_W-1:0] max_dark_count;
  } cfg_t;

  typedef struct packed {
    logic                led_on;
    logic                toggled;
    mode_t               mode_now;
    logic [SAMPLE_W-1:0] baseline_now;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/lgt_cfg.sv @@
// ---------------------------------------------------------------------------
// lgt_cfg: configuration register file
// Holds the two Q0.16 ratios and the dark count limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgt_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [lgt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [lgt_pkg::CFG_DATA_W-1:0] wr_data,
  output lgt_pkg::cfg_t                     cfg
);
  import lgt_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.down_ratio     <= 16'd32768;
      cfg_r.recover_ratio  <= 16'd58982;
      cfg_r.min_dark_count <= 8'd5;
      cfg_r.max_dark_count <= 8'd30;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DOWN_RATIO:    cfg_r.down_ratio     <= wr_data[RATIO_W-1:0];
        CFG_RECOVER_RATIO: cfg_r.recover_ratio  <= wr_data[RATIO_W-1:0];
        CFG_MIN_DARK:      cfg_r.min_dark_count <= wr_data[COUNT_W-1:0];
        CFG_MAX_DARK:      cfg_r.max_dark_count <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/lgt_core.sv @@
// ---------------------------------------------------------------------------
// lgt_core: mode state machine and per-sample update
// Calibrates the baseline, watches for occlusion and counts dark samples.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgt_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [lgt_pkg::SAMPLE_W-1:0] sample,
  input  wire lgt_pkg::cfg_t              cfg,
  output lgt_pkg::res_t                   res
);
  import lgt_pkg::*;

  mode_t               mode_r,     mode_nxt;
  logic [ACC_W-1:0]    acc_r,      acc_nxt;
  logic [CCNT_W-1:0]   ccnt_r,     ccnt_nxt;
  logic [SAMPLE_W-1:0] baseline_r, baseline_nxt;
  logic [COUNT_W-1:0]  dark_r,     dark_nxt;
  logic                lamp_r,     lamp_nxt;
  logic                toggled;

  logic [ACC_W-1:0]         acc_sum;
  logic [CCNT_W:0]          ccnt_inc;
  logic [ACC_W+DIV_M_W-1:0] div_prod;
  logic [RATIO_W-1:0]       ratio;
  logic [PROD_W-1:0]        thresh;
  logic [PROD_W-1:0]        scaled;
  logic                     dark;

  // Mean of the calibration samples through a reciprocal multiply
  assign acc_sum  = acc_r + ACC_W'(sample);
  assign ccnt_inc = {1'b0, ccnt_r} + (CCNT_W+1)'(1);
  assign div_prod = (ACC_W+DIV_M_W)'(acc_sum) * (ACC_W+DIV_M_W)'(DIV_MULT);

  // Q0.16 compare: sample * 2^16 < baseline * ratio
  assign ratio  = (mode_r == MODE_CHECK) ? cfg.recover_ratio : cfg.down_ratio;
  assign thresh = PROD_W'(baseline_r) * PROD_W'(ratio);
  assign scaled = {sample, {FRAC_W{1'b0}}};
  assign dark   = (baseline_r != '0) && (scaled < thresh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CALIB;
      acc_r      <= '0;
      ccnt_r     <= '0;
      baseline_r <= BASELINE_RST;
      dark_r     <= '0;
      lamp_r     <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      acc_r      <= acc_nxt;
      ccnt_r     <= ccnt_nxt;
      baseline_r <= baseline_nxt;
      dark_r     <= dark_nxt;
      lamp_r     <= lamp_nxt;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    acc_nxt      = acc_r;
    ccnt_nxt     = ccnt_r;
    baseline_nxt = baseline_r;
    dark_nxt     = dark_r;
    lamp_nxt     = lamp_r;
    toggled      = 1'b0;
    case (mode_r)
      MODE_CALIB: begin
        if (ccnt_inc >= (CCNT_W+1)'(AVG_SAMPLES)) begin
          baseline_nxt = div_prod[DIV_SH +: SAMPLE_W];
          mode_nxt     = MODE_WATCH;
          acc_nxt      = '0;
          ccnt_nxt     = '0;
        end else begin
          acc_nxt  = acc_sum;
          ccnt_nxt = ccnt_inc[CCNT_W-1:0];
        end
      end
      MODE_WATCH: begin
        if (dark) begin
          mode_nxt = MODE_CHECK;
          dark_nxt = '0;
        end
      end
      MODE_CHECK: begin
        if (dark) begin
          if (dark_r < cfg.max_dark_count) begin
            dark_nxt = dark_r + COUNT_W'(1);
          end else begin
            // count at the limit: abandon the check
            mode_nxt = MODE_WATCH;
            dark_nxt = '0;
          end
        end else begin
          if (dark_r >= cfg.min_dark_count && dark_r <= cfg.max_dark_count) begin
            lamp_nxt = ~lamp_r;
            toggled  = 1'b1;
          end
          mode_nxt = MODE_WATCH;
          dark_nxt = '0;
        end
      end
      default: begin
        mode_nxt = MODE_WATCH;
        dark_nxt = '0;
      end
    endcase
  end

  assign res.led_on       = lamp_nxt;
  assign res.toggled      = toggled;
  assign res.mode_now     = mode_nxt;
  assign res.baseline_now = baseline_nxt;

endmodule

`default_nettype wire

@@ rtl/light_occlusion_gesture_toggle.sv @@
// Path: an accepted sample is held in the input register, then its result is
//   registered in the result register once that register is free.
// Throughput: one item per cycle unless the result side stalls; the baseline
//   multiply and compare, the calibration mean and the mode update are combinational.
// Reset (rst_n low, synchronous): both pipeline stages empty, calibrating,
//   baseline 20, lamp off, registers at their defaults.
// ---------------------------------------------------------------------------
// light_occlusion_gesture_toggle: top level
// Input register, per-sample core and result register with handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module light_occlusion_gesture_toggle (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lgt_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_led_on,
  output logic                              out_toggled,
  output logic [lgt_pkg::MODE_W-1:0]          out_mode_now,
  output logic [lgt_pkg::SAMPLE_W-1:0]        out_baseline_now,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lgt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lgt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lgt_pkg::*;

  cfg_t                cfg;
  res_t                res;
  res_t                res_r;
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_valid_r;
  logic                adv;

  assign cfg_ready = 1'b1;

  lgt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held item when the result register is free
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  lgt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .sample (s1_sample_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_on       = res_r.led_on;
  assign out_toggled      = res_r.toggled;
  assign out_mode_now     = res_r.mode_now;
  assign out_baseline_now = res_r.baseline_now;

endmodule

`default_nettype wire

@@ rtl/lgt_checker.sv @@
// ---------------------------------------------------------------------------
// lgt_checker: port-level assertions for the gesture toggle
// Watches the result channel over time; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_led_on,
  input wire logic                       out_toggled,
  input wire logic [lgt_pkg::MODE_W-1:0]   out_mode_now,
  input wire logic [lgt_pkg::SAMPLE_W-1:0] out_baseline_now
);
  import lgt_pkg::*;

  // Result channel comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_on) &&
      $stable(out_toggled) && $stable(out_mode_now) && $stable(out_baseline_now))
    else $error("stalled result changed");

  // A completed gesture always returns to watching
  a_toggle_watch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_toggled |-> out_mode_now == MODE_WATCH)
    else $error("toggle outside watch mode");

  // Baseline keeps its reset value until calibration finishes
  a_calib_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_now == MODE_CALIB |-> out_baseline_now == BASELINE_RST)
    else $error("baseline changed during calibration");

endmodule

bind light_occlusion_gesture_toggle lgt_checker u_lgt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_led_on       (out_led_on),
  .out_toggled      (out_toggled),
  .out_mode_now     (out_mode_now),
  .out_baseline_now (out_baseline_now)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for light_occlusion_gesture_toggle
// Drives sensor samples and register writes over valid/ready channels and
// checks every result against a cycle-free model of the calibrate, watch
// and check modes. A directed plan is followed by random phases of gesture
// sequences under varied thresholds, with random stalls on both sides.
// ---------------------------------------------------------------------------

module tb_top;
  import lgt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 80;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    bit                    typed;
    res_t                  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_led_on;
  logic                  out_toggled;
  logic [MODE_W-1:0]     out_mode_now;
  logic [SAMPLE_W-1:0]   out_baseline_now;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state and register copy
  mode_t               lamp_mode;
  int unsigned         calib_sum;
  int unsigned         calib_seen;
  logic [SAMPLE_W-1:0] lamp_base;
  logic [COUNT_W-1:0]  dark_run;
  logic                lamp_lit;
  cfg_t                thresholds;

  res_t      pending_states[$];
  plan_row_t plan[$];
  bit        idle_on = 1'b1;
  int        n_errors = 0;
  int        n_cycles = 0;
  int        stall_left = 0;

  light_occlusion_gesture_toggle dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_on       (out_led_on),
    .out_toggled      (out_toggled),
    .out_mode_now     (out_mode_now),
    .out_baseline_now (out_baseline_now),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_shaded(input logic [SAMPLE_W-1:0] s,
                                   input logic [RATIO_W-1:0] ratio);
    return lamp_base != '0 && ({s, 16'h0000} < 32'(lamp_base) * 32'(ratio));
  endfunction

  function automatic res_t next_lamp_state(input logic [SAMPLE_W-1:0] s);
    res_t r;
    r = '0;
    case (lamp_mode)
      MODE_CALIB: begin
        calib_sum  = calib_sum + s;
        calib_seen = calib_seen + 1;
        if (calib_seen >= AVG_SAMPLES) begin
          lamp_base  = SAMPLE_W'(calib_sum / AVG_SAMPLES);
          lamp_mode  = MODE_WATCH;
          calib_sum  = 0;
          calib_seen = 0;
        end
      end
      MODE_WATCH: begin
        if (is_shaded(s, thresholds.down_ratio)) begin
          lamp_mode = MODE_CHECK;
          dark_run  = '0;
        end
      end
      default: begin
        if (is_shaded(s, thresholds.recover_ratio)) begin
          if (dark_run < thresholds.max_dark_count) begin
            dark_run = dark_run + 8'd1;
          end else begin
            lamp_mode = MODE_WATCH;
            dark_run  = '0;
          end
        end else begin
          if (dark_run >= thresholds.min_dark_count &&
              dark_run <= thresholds.max_dark_count) begin
            lamp_lit  = ~lamp_lit;
            r.toggled = 1'b1;
          end
          lamp_mode = MODE_WATCH;
          dark_run  = '0;
        end
      end
    endcase
    r.led_on       = lamp_lit;
    r.mode_now     = lamp_mode;
    r.baseline_now = lamp_base;
    return r;
  endfunction

  // number of sample values that count as dark for this ratio
  function automatic int dark_edge(input logic [RATIO_W-1:0] ratio);
    int unsigned prod;
    prod = 32'(lamp_base) * 32'(ratio);
    if (lamp_base == '0) return 0;
    return int'((prod + 32'd65535) >> 16);
  endfunction

  function automatic logic [SAMPLE_W-1:0] dark_sample(input logic [RATIO_W-1:0] ratio);
    int lim;
    lim = dark_edge(ratio);
    if (lim == 0) return SAMPLE_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 3) == 0) return SAMPLE_W'(lim - 1);
    return SAMPLE_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] bright_sample(input logic [RATIO_W-1:0] ratio);
    int lim;
    lim = dark_edge(ratio);
    if ($urandom_range(0, 3) == 0) return SAMPLE_W'(lim);
    return SAMPLE_W'($urandom_range(lim, 4095));
  endfunction

  function automatic void plan_sample(input int s);
    plan_row_t row;
    row        = '{default: '0};
    row.val    = CFG_DATA_W'(s);
    plan.push_back(row);
  endfunction

  function automatic void plan_checked(input int s, input logic led, input logic tog,
                                       input mode_t m, input int base);
    plan_row_t row;
    row        = '{default: '0};
    row.val    = CFG_DATA_W'(s);
    row.typed  = 1'b1;
    row.want   = '{led_on: led, toggled: tog, mode_now: m,
                   baseline_now: SAMPLE_W'(base)};
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t row;
    row        = '{default: '0};
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = CFG_DATA_W'(val);
    plan.push_back(row);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input res_t want);
    res_t model;
    cfg_valid <= 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    model = next_lamp_state(s);
    pending_states.push_back(typed ? want : model);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_DOWN_RATIO:    thresholds.down_ratio     = val;
      CFG_RECOVER_RATIO: thresholds.recover_ratio  = val;
      CFG_MIN_DARK:      thresholds.min_dark_count = val[COUNT_W-1:0];
      CFG_MAX_DARK:      thresholds.max_dark_count = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  // one occlusion: a dark start, a run of dark samples, then a release (sometimes a random sample)
  task automatic play_gesture(output int n_sent);
    int lo;
    int hi;
    int pick;
    int k;
    lo   = thresholds.min_dark_count;
    hi   = thresholds.max_dark_count;
    pick = $urandom_range(0, 9);
    if (pick < 6)      k = $urandom_range(lo, (hi > lo + 12) ? lo + 12 : hi);
    else if (pick < 8) k = $urandom_range(0, lo);
    else               k = hi + $urandom_range(0, 2);
    n_sent = k + 2;
    send_sample(dark_sample(thresholds.down_ratio), 1'b0, '0);
    repeat (k) send_sample(dark_sample(thresholds.recover_ratio), 1'b0, '0);
    if ($urandom_range(0, 9) == 0) send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, '0);
    else send_sample(bright_sample(thresholds.recover_ratio), 1'b0, '0);
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_states.size() == 0) begin
        $error("result with no sample pending: led_on %0b mode_now %0d",
               out_led_on, out_mode_now);
        n_errors++;
      end else begin
        want = pending_states.pop_front();
        if (out_led_on !== want.led_on) begin
          $error("led_on: expected %0b, got %0b", want.led_on, out_led_on);
          n_errors++;
        end
        if (out_toggled !== want.toggled) begin
          $error("toggled: expected %0b, got %0b", want.toggled, out_toggled);
          n_errors++;
        end
        if (out_mode_now !== want.mode_now) begin
          $error("mode_now: expected %0d, got %0d", want.mode_now, out_mode_now);
          n_errors++;
        end
        if (out_baseline_now !== want.baseline_now) begin
          $error("baseline_now: expected %0d, got %0d", want.baseline_now,
                 out_baseline_now);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int ph;
    int target;
    int n_items;
    int mn;
    int mx;
    int sent;
    logic [RATIO_W-1:0] dr;
    logic [RATIO_W-1:0] rr;

    lamp_mode  = MODE_CALIB;
    calib_sum  = 0;
    calib_seen = 0;
    lamp_base  = BASELINE_RST;
    dark_run   = '0;
    lamp_lit   = 1'b0;
    thresholds = '{down_ratio: 16'd32768, recover_ratio: 16'd58982,
                   min_dark_count: 8'd5, max_dark_count: 8'd30};

    // calibration: mean of 0, 4095 and eighteen 2000s truncates to 2004
    plan_checked(0, 1'b0, 1'b0, MODE_CALIB, 20);
    plan_checked(4095, 1'b0, 1'b0, MODE_CALIB, 20);
    repeat (8) plan_sample(2000);
    // new limits mid-calibration only matter once watching
    plan_reg(CFG_MIN_DARK, 0);
    plan_reg(CFG_MAX_DARK, 0);
    repeat (9) plan_sample(2000);
    plan_checked(2000, 1'b0, 1'b0, MODE_WATCH, 2004);
    plan_checked(4095, 1'b0, 1'b0, MODE_WATCH, 2004);
    plan_checked(0, 1'b0, 1'b0, MODE_CHECK, 2004);
    // dark with the count already at the maximum: abandon
    plan_checked(0, 1'b0, 1'b0, MODE_WATCH, 2004);
    plan_checked(0, 1'b0, 1'b0, MODE_CHECK, 2004);
    plan_checked(4095, 1'b1, 1'b1, MODE_WATCH, 2004);
    plan_reg(CFG_DOWN_RATIO, 65535);
    plan_reg(CFG_RECOVER_RATIO, 0);
    plan_reg(CFG_MIN_DARK, 255);
    plan_reg(CFG_MAX_DARK, 255);
    plan_sample(2003);
    plan_sample(0);
    plan_reg(CFG_DOWN_RATIO, 0);
    plan_sample(0);
    plan_reg(CFG_DOWN_RATIO, 32768);
    plan_reg(CFG_RECOVER_RATIO, 65535);
    plan_reg(CFG_MIN_DARK, 1);
    plan_reg(CFG_MAX_DARK, 3);
    plan_sample(1001);
    plan_sample(2003);
    plan_sample(2003);
    // lower the maximum under a running check: the release must not toggle
    plan_reg(CFG_MAX_DARK, 1);
    plan_sample(2004);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].val[SAMPLE_W-1:0], plan[i].typed, plan[i].want);
      end
    end

    n_items = 0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin dr = 16'd32768; rr = 16'd58982; mn = 5;   mx = 30;  end
        1: begin dr = 16'hFFFF;  rr = 16'hFFFF;  mn = 0;   mx = 255; end
        2: begin dr = 16'hFFFF;  rr = 16'hFFFF;  mn = 255; mx = 255; end
        3: begin
          dr = RATIO_W'($urandom_range(1, 65535));
          rr = RATIO_W'($urandom_range(1, 65535));
          mn = 0;
          mx = 0;
        end
        default: begin
          dr = RATIO_W'($urandom_range(1, 65535));
          rr = RATIO_W'($urandom_range(1, 65535));
          mn = $urandom_range(0, 8);
          mx = mn + $urandom_range(0, 12) - 2;
          if (mx < 0) mx = 0;
        end
      endcase
      write_reg(CFG_DOWN_RATIO, dr);
      write_reg(CFG_RECOVER_RATIO, rr);
      write_reg(CFG_MIN_DARK, CFG_DATA_W'(mn));
      write_reg(CFG_MAX_DARK, CFG_DATA_W'(mx));
      target = n_items + PHASE_ITEMS;
      while (n_items < target) begin
        idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 5) == 0) begin
          int burst;
          burst = $urandom_range(1, 4);
          repeat (burst) send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, '0);
          n_items += burst;
        end else begin
          play_gesture(sent);
          n_items += sent;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (n_errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
